[hw/rtl/assert_macros.svh]
// Assertion macros shared by the particulate sensor frame parser RTL.
// Standalone header; modules that assert include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, ignored while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked on every edge
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[hw/rtl/pmfp_pkg.sv]
// Package for the particulate sensor frame parser: frame constants,
// byte position codes and the frame hand-off type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmfp_pkg;

    localparam int BYTE_W       = 8;
    localparam int RAW_W        = 16;
    localparam int PM_W         = 13;
    localparam int POS_W        = 4;

    localparam int FRAME_LENGTH = 10;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hC0;

    // Byte position codes within a frame
    localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR2  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_P25_L = POS_W'(2);
    localparam logic [POS_W-1:0] POS_P25_H = POS_W'(3);
    localparam logic [POS_W-1:0] POS_P10_L = POS_W'(4);
    localparam logic [POS_W-1:0] POS_P10_H = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PAY_E = POS_W'(7);
    localparam logic [POS_W-1:0] POS_CSUM  = POS_W'(FRAME_LENGTH - 2);
    localparam logic [POS_W-1:0] POS_TAIL  = POS_W'(FRAME_LENGTH - 1);

    // Divide by ten as multiply by ceil(2^19 / 10) then shift right by 19;
    // exact for every 16-bit dividend
    localparam int DIV10_SHIFT = 19;
    localparam int PROD_W      = RAW_W + RAW_W;
    localparam logic [RAW_W-1:0] DIV10_RECIP = RAW_W'(52429);

    // Completed frame handed from parser to output stage
    typedef struct packed {
        logic [RAW_W-1:0] pm25_raw;
        logic [RAW_W-1:0] pm10_raw;
    } t_frame;

endpackage

`default_nettype wire

[hw/rtl/pmfp_parse.sv]
// Byte-wise frame parser: header hunt, payload capture and checksum check.
// Depends on pmfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pmfp_parse
    import pmfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_valid,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   o_rx_ready,
    output logic                   o_frm_valid,
    output t_frame                 o_frm,
    input  wire logic              i_frm_ready
);

    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [BYTE_W-1:0] r_sum,       n_sum;
    logic [RAW_W-1:0]  r_pm25_raw,  n_pm25_raw;
    logic [RAW_W-1:0]  r_pm10_raw,  n_pm10_raw;
    logic              r_sum_ok,    n_sum_ok;
    logic              r_frm_valid, n_frm_valid;
    logic              w_take;
    logic              w_emit;

    // Stall input only while a finished frame cannot drain
    assign o_rx_ready = !r_frm_valid || i_frm_ready;
    assign w_take     = i_rx_valid && o_rx_ready;
    assign w_emit     = w_take && (r_pos == POS_TAIL) && r_sum_ok;

    // Advance the frame position for each accepted beat
    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_pm25_raw = r_pm25_raw;
        n_pm10_raw = r_pm10_raw;
        n_sum_ok   = r_sum_ok;
        if (w_take) begin
            if (r_pos == POS_HUNT || r_pos > POS_TAIL) begin
                n_pos = (i_rx_byte == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
            end else if (r_pos == POS_HDR2) begin
                if (i_rx_byte == HDR_SECOND) begin
                    n_pos    = POS_P25_L;
                    n_sum    = '0;
                    n_sum_ok = 1'b0;
                end else if (i_rx_byte == HDR_FIRST) begin
                    n_pos = POS_HDR2;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos <= POS_PAY_E) begin
                n_sum = r_sum + i_rx_byte;
                case (r_pos)
                    POS_P25_L: n_pm25_raw = {r_pm25_raw[RAW_W-1:BYTE_W], i_rx_byte};
                    POS_P25_H: n_pm25_raw = {i_rx_byte, r_pm25_raw[BYTE_W-1:0]};
                    POS_P10_L: n_pm10_raw = {r_pm10_raw[RAW_W-1:BYTE_W], i_rx_byte};
                    POS_P10_H: n_pm10_raw = {i_rx_byte, r_pm10_raw[BYTE_W-1:0]};
                    default:   ;
                endcase
                n_pos = r_pos + POS_W'(1);
            end else if (r_pos == POS_CSUM) begin
                n_sum_ok = (i_rx_byte == r_sum);
                n_pos    = r_pos + POS_W'(1);
            end else begin
                // tail byte: value not checked
                n_pos = POS_HUNT;
            end
        end
    end

    // Hold a finished frame until the output stage takes it
    always_comb begin
        n_frm_valid = r_frm_valid;
        if (w_emit) begin
            n_frm_valid = 1'b1;
        end else if (i_frm_ready) begin
            n_frm_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HUNT;
            r_sum       <= '0;
            r_pm25_raw  <= '0;
            r_pm10_raw  <= '0;
            r_sum_ok    <= 1'b0;
            r_frm_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_pm25_raw  <= n_pm25_raw;
            r_pm10_raw  <= n_pm10_raw;
            r_sum_ok    <= n_sum_ok;
            r_frm_valid <= n_frm_valid;
        end
    end

    // Raw values stay put while a frame waits: new payload needs accepted beats
    assign o_frm_valid = r_frm_valid;
    assign o_frm       = '{pm25_raw: r_pm25_raw, pm10_raw: r_pm10_raw};

    `ASSERT_CLK(a_pos_range, i_clk, i_rst_n, r_pos <= POS_TAIL, "frame position out of range")
    `ASSERT_CLK(a_emit_on_tail, i_clk, i_rst_n,
        (r_frm_valid && !$past(r_frm_valid)) |-> $past(w_emit),
        "frame emitted without a matched tail beat")

endmodule

`default_nettype wire

[hw/rtl/pmfp_out.sv]
// Output stage: divides both raw readings by ten and holds the result beat.
// Depends on pmfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pmfp_out
    import pmfp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_frm_valid,
    input  wire t_frame          i_frm,
    output logic                 o_frm_ready,
    output logic                 o_pm_valid,
    output logic [PM_W-1:0]      o_pm25_value,
    output logic [PM_W-1:0]      o_pm10_value,
    input  wire logic            i_pm_ready
);

    logic              r_valid;
    logic [PM_W-1:0]   r_pm25;
    logic [PM_W-1:0]   r_pm10;
    logic              w_load;
    logic [PROD_W-1:0] w_prod25;
    logic [PROD_W-1:0] w_prod10;

    assign o_frm_ready = !r_valid || i_pm_ready;
    assign w_load      = i_frm_valid && o_frm_ready;

    // Divide by ten through the reciprocal multiply
    assign w_prod25 = PROD_W'(i_frm.pm25_raw) * PROD_W'(DIV10_RECIP);
    assign w_prod10 = PROD_W'(i_frm.pm10_raw) * PROD_W'(DIV10_RECIP);

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_pm_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pm25 <= w_prod25[DIV10_SHIFT +: PM_W];
            r_pm10 <= w_prod10[DIV10_SHIFT +: PM_W];
        end
    end

    assign o_pm_valid   = r_valid;
    assign o_pm25_value = r_pm25;
    assign o_pm10_value = r_pm10;

    `ASSERT_CLK(a_load_shows, i_clk, i_rst_n, w_load |=> o_pm_valid, "loaded frame not presented")
    `ASSERT_CLK(a_quot_range, i_clk, i_rst_n,
        o_pm_valid |-> (o_pm25_value <= PM_W'(6553) && o_pm10_value <= PM_W'(6553)),
        "quotient above sixteen-bit range over ten")

endmodule

`default_nettype wire

[hw/rtl/pm_sensor_frame_parser_core.sv]
// Top level of the particulate sensor frame parser.
// Depends on pmfp_pkg, pmfp_parse and pmfp_out.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per beat, hunts for the header 0xAA 0xC0 and
// collects the rest of the ten-byte frame. When the tail byte arrives and
// the sum of payload bytes 2 to 7 (modulo 256) equals byte 8, one result
// beat carries PM2.5 and PM10, each the little-endian 16-bit raw reading
// divided by ten. A byte is accepted every cycle while input is not
// stalled; a result passes the parser register, then the divide-by-ten
// multiply into the output register. Both the parser and the output
// stage hold a frame, so input stalls only when both are full and the
// result side is not taking.
module pm_sensor_frame_parser_core
    import pmfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_valid,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   o_rx_ready,
    output logic                   o_pm_valid,
    output logic [PM_W-1:0]        o_pm25_value,
    output logic [PM_W-1:0]        o_pm10_value,
    input  wire logic              i_pm_ready
);

    logic   w_frm_valid;
    logic   w_frm_ready;
    t_frame w_frm;

    // Header hunt and frame capture
    pmfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_rx_ready  (o_rx_ready),
        .o_frm_valid (w_frm_valid),
        .o_frm       (w_frm),
        .i_frm_ready (w_frm_ready)
    );

    // Scale and present the result beat
    pmfp_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frm_valid  (w_frm_valid),
        .i_frm        (w_frm),
        .o_frm_ready  (w_frm_ready),
        .o_pm_valid   (o_pm_valid),
        .o_pm25_value (o_pm25_value),
        .o_pm10_value (o_pm10_value),
        .i_pm_ready   (i_pm_ready)
    );

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for pm_sensor_frame_parser_core: drives received bytes with random
// gaps, checks each PM result against a cycle-free frame predictor held here.
// Depends on pmfp_pkg and the parser RTL.

module tb;
    import pmfp_pkg::*;

    localparam int TOTAL_BYTES  = 1400;
    localparam int MID_BYTES    = 700;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PM_SCALE     = 10;
    localparam int N_DIRECTED   = 33;

    // Idling styles for either side
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_FULL  = 1;
    localparam int IDLE_SPARSE = 2;

    typedef struct packed {
        logic [PM_W-1:0] pm25;
        logic [PM_W-1:0] pm10;
    } t_pm_reading;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              typed;
        t_pm_reading       want;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_rx_valid = 1'b0;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              i_pm_ready = 1'b0;
    logic              o_rx_ready;
    logic              o_pm_valid;
    logic [PM_W-1:0]   o_pm25_value;
    logic [PM_W-1:0]   o_pm10_value;

    // Frame predictor state
    logic [POS_W-1:0]  fp_pos = POS_HUNT;
    logic [BYTE_W-1:0] fp_sum = '0;
    logic [RAW_W-1:0]  fp_pm25 = '0;
    logic [RAW_W-1:0]  fp_pm10 = '0;
    logic              fp_sum_ok = 1'b0;

    t_pm_reading       pending_readings[$];
    logic [BYTE_W-1:0] rx_script[$];
    int                n_fail = 0;
    int                sent_bytes = 0;
    int                tx_mode = IDLE_NONE;
    int                rx_mode = IDLE_FULL;
    int                cycle_count = 0;

    // Directed frames: stray header byte, repeated first header byte, all-zero
    // frame, all-ones readings with header bytes inside the payload, bad checksum
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{8'hAA, 1'b0, '0}, '{8'h12, 1'b0, '0},
        '{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hC0, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'hFF, 1'b1, '{13'd0, 13'd0}},
        '{8'hAA, 1'b0, '0}, '{8'hC0, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hC0, 1'b0, '0},
        '{8'h66, 1'b0, '0}, '{8'h00, 1'b1, '{13'd6553, 13'd6553}},
        '{8'hAA, 1'b0, '0}, '{8'hC0, 1'b0, '0},
        '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0}
    };

    pm_sensor_frame_parser_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .i_rx_byte    (i_rx_byte),
        .o_rx_ready   (o_rx_ready),
        .o_pm_valid   (o_pm_valid),
        .o_pm25_value (o_pm25_value),
        .o_pm10_value (o_pm10_value),
        .i_pm_ready   (i_pm_ready)
    );

    always #10 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_wait(input int mode);
        int w;
        case (mode)
            IDLE_NONE: w = 0;
            IDLE_FULL: w = $urandom_range(0, 16);
            default:   w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
        return w;
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        logic [RAW_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = RAW_W'($urandom_range(0, 255));
            1:       v = '1;
            2:       v = RAW_W'($urandom_range(65520, 65535));
            3:       v = '0;
            default: v = RAW_W'($urandom);
        endcase
        return v;
    endfunction

    // Advance the frame predictor by one byte; return 1 when a reading is due
    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b,
                                         output logic [PM_W-1:0] v25,
                                         output logic [PM_W-1:0] v10);
        bit got;
        got = 1'b0;
        v25 = '0;
        v10 = '0;
        if (fp_pos == POS_HUNT || fp_pos > POS_TAIL) begin
            fp_pos = (b == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
        end else if (fp_pos == POS_HDR2) begin
            if (b == HDR_SECOND) begin
                fp_pos    = POS_P25_L;
                fp_sum    = '0;
                fp_sum_ok = 1'b0;
            end else if (b != HDR_FIRST) begin
                fp_pos = POS_HUNT;
            end
        end else if (fp_pos <= POS_PAY_E) begin
            fp_sum = fp_sum + b;
            case (fp_pos)
                POS_P25_L: fp_pm25[7:0]  = b;
                POS_P25_H: fp_pm25[15:8] = b;
                POS_P10_L: fp_pm10[7:0]  = b;
                POS_P10_H: fp_pm10[15:8] = b;
                default: ;
            endcase
            fp_pos = fp_pos + 1'b1;
        end else if (fp_pos == POS_CSUM) begin
            fp_sum_ok = (b == fp_sum);
            fp_pos    = fp_pos + 1'b1;
        end else begin
            // Tail byte closes the frame
            fp_pos = POS_HUNT;
            if (fp_sum_ok) begin
                got = 1'b1;
                v25 = PM_W'(fp_pm25 / PM_SCALE);
                v10 = PM_W'(fp_pm10 / PM_SCALE);
            end
        end
        return got;
    endfunction

    // Send one byte beat, then predict on acceptance
    task automatic push_rx_byte(input logic [BYTE_W-1:0] b, input bit typed,
                                input t_pm_reading want);
        int              gap;
        bit              got;
        logic [PM_W-1:0] v25;
        logic [PM_W-1:0] v10;
        t_pm_reading     r;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        got = parse_rx_byte(b, v25, v10);
        if (typed) begin
            pending_readings.push_back(want);
        end else if (got) begin
            r.pm25 = v25;
            r.pm10 = v10;
            pending_readings.push_back(r);
        end
        sent_bytes++;
        if (sent_bytes % 64 == 0) tx_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
    endtask

    // Hold the sender until every due reading has come out
    task automatic drain_readings();
        i_rx_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    // Result side: random stalls, check each beat against the oldest reading
    initial begin : result_side
        int          w;
        int          n_seen;
        t_pm_reading exp_r;
        n_seen = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = draw_wait(rx_mode);
            if (w > 0) begin
                i_pm_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_pm_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_pm_valid) @(posedge i_clk);
            if (pending_readings.size() == 0) begin
                $error("unexpected result: pm25_value %0d, pm10_value %0d",
                       o_pm25_value, o_pm10_value);
                n_fail++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (o_pm25_value !== exp_r.pm25) begin
                    $error("pm25_value: expected %0d, got %0d", exp_r.pm25, o_pm25_value);
                    n_fail++;
                end
                if (o_pm10_value !== exp_r.pm10) begin
                    $error("pm10_value: expected %0d, got %0d", exp_r.pm10, o_pm10_value);
                    n_fail++;
                end
            end
            n_seen++;
            if (n_seen % 8 == 0) rx_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
        end
    end

    initial begin : byte_side
        int                kind;
        int                n;
        bit                paused_mid;
        logic [RAW_W-1:0]  r25;
        logic [RAW_W-1:0]  r10;
        logic [BYTE_W-1:0] p6;
        logic [BYTE_W-1:0] p7;
        logic [BYTE_W-1:0] csum;
        logic [BYTE_W-1:0] nb;
        paused_mid = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames
        for (int k = 0; k < N_DIRECTED; k++) begin
            push_rx_byte(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].want);
        end
        drain_readings();

        // Random frames, noise and broken sequences
        while (sent_bytes < TOTAL_BYTES) begin
            kind = $urandom_range(0, 99);
            rx_script.delete();
            if (kind < 80) begin
                if ($urandom_range(0, 7) == 0) rx_script.push_back(HDR_FIRST);
                r25  = pick_raw();
                r10  = pick_raw();
                p6   = BYTE_W'($urandom);
                p7   = BYTE_W'($urandom);
                csum = r25[7:0] + r25[15:8] + r10[7:0] + r10[15:8] + p6 + p7;
                // Corrupt the checksum on some frames
                if (kind >= 70) csum = csum ^ BYTE_W'($urandom_range(1, 255));
                rx_script.push_back(HDR_FIRST);
                rx_script.push_back(HDR_SECOND);
                rx_script.push_back(r25[7:0]);
                rx_script.push_back(r25[15:8]);
                rx_script.push_back(r10[7:0]);
                rx_script.push_back(r10[15:8]);
                rx_script.push_back(p6);
                rx_script.push_back(p7);
                rx_script.push_back(csum);
                rx_script.push_back(BYTE_W'($urandom));
            end else if (kind < 90) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        nb = $urandom_range(0, 1) ? HDR_FIRST : HDR_SECOND;
                    else
                        nb = BYTE_W'($urandom);
                    rx_script.push_back(nb);
                end
            end else begin
                rx_script.push_back(HDR_FIRST);
                if ($urandom_range(0, 1)) begin
                    rx_script.push_back(BYTE_W'($urandom));
                end else begin
                    // Truncated frame: the next header lands mid-frame
                    rx_script.push_back(HDR_SECOND);
                    n = $urandom_range(1, 7);
                    repeat (n) rx_script.push_back(BYTE_W'($urandom));
                end
            end
            foreach (rx_script[k]) push_rx_byte(rx_script[k], 1'b0, '0);
            if (!paused_mid && sent_bytes >= MID_BYTES) begin
                drain_readings();
                paused_mid = 1'b1;
            end
        end

        // Wait out the remaining readings, then watch for strays
        drain_readings();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[pm_sensor_frame_parser_core.f]
+incdir+hw/rtl
hw/rtl/pmfp_pkg.sv
hw/rtl/pmfp_parse.sv
hw/rtl/pmfp_out.sv
hw/rtl/pm_sensor_frame_parser_core.sv
sim/tb.sv
